// ===== rtl/psfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfr_pkg: shared types and constants of the fragment reassembler
// Result kinds, field widths, default sizing and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package psfr_pkg;

   localparam int PSFR_SESSION_SLOTS     = 8;
   localparam int PSFR_MAX_MESSAGE_BYTES = 2048;

   localparam int SESSION_W = 32;
   localparam int BYTE_W    = 8;
   localparam int RSLOT_W   = 3;
   localparam int ROFF_W    = 11;
   localparam int KIND_W    = 2;
   localparam int LENGTH_W  = 12;

   localparam logic [KIND_W-1:0] KIND_PASS  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RDATA = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RANGE = 2'd3;

   localparam logic ACTION_FRAGMENT = 1'b0;
   localparam logic ACTION_READ     = 1'b1;

   typedef struct packed {
      logic capture;   // load the accepted beat into the item registers
      logic commit;    // apply a fragment beat to slot state and store
      logic rd_issue;  // launch the store read of a read access
      logic load_rd;   // move read data into the result register
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic has_result;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/per_session_fragment_reassembler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_session_fragment_reassembler_core: per-session fragment reassembly
// Collects fragment bytes into per-session slot buffers and reports each
// completed message; passes unfragmented bytes through and serves reads.
// ----------------------------------------------------------------------------
// One beat is handled at a time by a sequencer in front of the slot table:
// a fragment beat steps through capture, then lookup and update of the
// slot table and message store; a read beat steps through capture, store
// read and result load. A beat that produces a result waits in its last
// step while the result register still holds an untaken beat, so the input
// side may accept the next beat while a result is pending. The message
// store is one SESSION_SLOTS x MAX_MESSAGE_BYTES byte memory with one write
// and one registered read port; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module per_session_fragment_reassembler_core
   import psfr_pkg::*;
#(
   parameter int SESSION_SLOTS     = PSFR_SESSION_SLOTS,
   parameter int MAX_MESSAGE_BYTES = PSFR_MAX_MESSAGE_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  logic [SESSION_W-1:0] req_session_key,
   input  logic                 req_begin_flag,
   input  logic                 req_end_flag,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_fragment_last,
   input  logic [RSLOT_W-1:0]   req_read_slot,
   input  logic [ROFF_W-1:0]    req_read_offset,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [SESSION_W-1:0] rsp_out_session,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_message_last,
   output logic [RSLOT_W-1:0]   rsp_done_slot,
   output logic [LENGTH_W-1:0]  rsp_message_length,
   output logic                 rsp_overflowed
);

   cmd_type    cmd;
   status_type status;

   psfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   psfr_datapath #(
      .SESSION_SLOTS     (SESSION_SLOTS),
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_action         (req_action),
      .req_session_key    (req_session_key),
      .req_begin_flag     (req_begin_flag),
      .req_end_flag       (req_end_flag),
      .req_data_byte      (req_data_byte),
      .req_fragment_last  (req_fragment_last),
      .req_read_slot      (req_read_slot),
      .req_read_offset    (req_read_offset),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_out_session    (rsp_out_session),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_message_last   (rsp_message_last),
      .rsp_done_slot      (rsp_done_slot),
      .rsp_message_length (rsp_message_length),
      .rsp_overflowed     (rsp_overflowed)
   );

`ifndef ASSERT_OFF
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.commit, cmd.rd_issue, cmd.load_rd}))
      else $error("more than one sequencer command in a cycle");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new beat taken while one is in work");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status.has_result) |=> rsp_valid)
      else $error("committed result did not reach the result register");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |=> !req_ready)
      else $error("read access released before its data was loaded");
`endif

endmodule

// ===== rtl/psfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfr_ctrl: item sequencer
// Takes one beat at a time, steps it through lookup/update or store read,
// and waits for the result register to free up before committing a result.
// ----------------------------------------------------------------------------
module psfr_ctrl
   import psfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_RDATA = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_read) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_RDATA;
            end else if (!status.has_result || status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_RDATA: begin
            if (status.out_free) begin
               cmd.load_rd = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/psfr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfr_datapath: slot table, message store and result register
// Holds the captured beat, looks up the session slot, appends bytes to the
// slot buffer and builds result beats.
// ----------------------------------------------------------------------------
module psfr_datapath
   import psfr_pkg::*;
#(
   parameter int SESSION_SLOTS     = PSFR_SESSION_SLOTS,
   parameter int MAX_MESSAGE_BYTES = PSFR_MAX_MESSAGE_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_action,
   input  logic [SESSION_W-1:0] req_session_key,
   input  logic                 req_begin_flag,
   input  logic                 req_end_flag,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_fragment_last,
   input  logic [RSLOT_W-1:0]   req_read_slot,
   input  logic [ROFF_W-1:0]    req_read_offset,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [SESSION_W-1:0] rsp_out_session,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_message_last,
   output logic [RSLOT_W-1:0]   rsp_done_slot,
   output logic [LENGTH_W-1:0]  rsp_message_length,
   output logic                 rsp_overflowed
);

   localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
   localparam int FILL_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int DEPTH  = SESSION_SLOTS * MAX_MESSAGE_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_MESSAGE_BYTES);
   localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(MAX_MESSAGE_BYTES);

   // captured beat
   logic                 act_ff;
   logic [SESSION_W-1:0] sid_ff;
   logic                 beg_ff;
   logic                 end_ff;
   logic [BYTE_W-1:0]    byte_ff;
   logic                 last_ff;
   logic [RSLOT_W-1:0]   rslot_ff;
   logic [ROFF_W-1:0]    roff_ff;

   // slot table
   logic [SESSION_W-1:0]     key_ff [SESSION_SLOTS];
   logic [FILL_W-1:0]        fill_ff [SESSION_SLOTS];
   logic [SESSION_SLOTS-1:0] used_ff;
   logic [SESSION_SLOTS-1:0] active_ff;
   logic [SESSION_SLOTS-1:0] ovf_ff;
   logic [SESSION_SLOTS-1:0] fopen_ff;

   // message store
   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_ok_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [SESSION_W-1:0] osess_ff, osess_in;
   logic [BYTE_W-1:0]    obyte_ff, obyte_in;
   logic                 mlast_ff, mlast_in;
   logic [RSLOT_W-1:0]   dslot_ff, dslot_in;
   logic [LENGTH_W-1:0]  mlen_ff, mlen_in;
   logic                 oovf_ff, oovf_in;

   logic              hit;
   logic [SLOT_W-1:0] hit_idx;
   logic              free_ok;
   logic [SLOT_W-1:0] free_idx;
   logic [SLOT_W-1:0] tgt;
   logic              is_frag;
   logic              pass;
   logic              claim;
   logic              do_append;
   logic              open_eff;
   logic              restart;
   logic [FILL_W-1:0] fill_base;
   logic              ovf_base;
   logic              room;
   logic [FILL_W-1:0] fill_in;
   logic              ovf_in;
   logic              complete;
   logic              has_result;
   logic [ADDR_W-1:0] wr_addr;
   logic [SLOT_W-1:0] rd_idx;
   logic              rd_ok;
   logic [ADDR_W-1:0] rd_addr;
   logic              out_load;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         sid_ff   <= req_session_key;
         beg_ff   <= req_begin_flag;
         end_ff   <= req_end_flag;
         byte_ff  <= req_data_byte;
         last_ff  <= req_fragment_last;
         rslot_ff <= req_read_slot;
         roff_ff  <= req_read_offset;
      end
   end

   // lowest matching slot and lowest free slot
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = SESSION_SLOTS - 1; i >= 0; i--) begin
         if (used_ff[i] && (key_ff[i] == sid_ff)) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (!used_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign tgt       = hit ? hit_idx : free_idx;
   assign is_frag   = (act_ff == ACTION_FRAGMENT);
   assign pass      = beg_ff && end_ff;
   assign claim     = beg_ff && !hit && free_ok;
   assign do_append = is_frag && !pass &&
                      (beg_ff ? (hit || free_ok) : (hit && active_ff[hit_idx]));
   // a begin byte inside an open fragment continues it
   assign open_eff  = claim ? 1'b0 : fopen_ff[tgt];
   assign restart   = beg_ff && !open_eff;
   assign fill_base = restart ? '0 : fill_ff[tgt];
   assign ovf_base  = restart ? 1'b0 : ovf_ff[tgt];
   assign room      = (fill_base < FILL_MAX);
   assign fill_in   = room ? (fill_base + FILL_W'(1)) : fill_base;
   assign ovf_in    = ovf_base || !room;
   assign complete  = do_append && !beg_ff && end_ff && last_ff;
   assign has_result = is_frag && (pass || complete);
   assign wr_addr   = ADDR_W'(tgt) * SLOT_SPAN + ADDR_W'(fill_base);

   assign rd_idx  = SLOT_W'(rslot_ff);
   assign rd_ok   = (32'(rslot_ff) < 32'(SESSION_SLOTS)) &&
                    (32'(roff_ff) < 32'(fill_ff[rd_idx]));
   assign rd_addr = ADDR_W'(rd_idx) * SLOT_SPAN + ADDR_W'(roff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         active_ff <= '0;
         ovf_ff    <= '0;
         fopen_ff  <= '0;
         for (int i = 0; i < SESSION_SLOTS; i++) begin
            key_ff[i]  <= '0;
            fill_ff[i] <= '0;
         end
      end else if (cmd.commit && do_append) begin
         if (claim) begin
            key_ff[tgt] <= sid_ff;
         end
         // release the slot once its message completes
         used_ff[tgt]   <= !complete;
         active_ff[tgt] <= !complete;
         fopen_ff[tgt]  <= !complete && !last_ff;
         fill_ff[tgt]   <= fill_in;
         ovf_ff[tgt]    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_append && room) begin
         mem[wr_addr] <= byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[rd_addr];
         rd_ok_ff   <= rd_ok;
      end
   end

   assign out_load = (cmd.commit && has_result) || cmd.load_rd;

   always_comb begin
      kind_in  = KIND_PASS;
      osess_in = '0;
      obyte_in = '0;
      mlast_in = 1'b0;
      dslot_in = '0;
      mlen_in  = '0;
      oovf_in  = 1'b0;
      if (cmd.load_rd) begin
         kind_in  = rd_ok_ff ? KIND_RDATA : KIND_RANGE;
         obyte_in = rd_ok_ff ? rd_data_ff : '0;
      end else if (pass) begin
         osess_in = sid_ff;
         obyte_in = byte_ff;
         mlast_in = last_ff;
      end else begin
         kind_in  = KIND_DONE;
         osess_in = key_ff[tgt];
         dslot_in = RSLOT_W'(tgt);
         mlen_in  = LENGTH_W'(fill_in);
         oovf_in  = ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         kind_ff  <= kind_in;
         osess_ff <= osess_in;
         obyte_ff <= obyte_in;
         mlast_ff <= mlast_in;
         dslot_ff <= dslot_in;
         mlen_ff  <= mlen_in;
         oovf_ff  <= oovf_in;
      end
   end

   assign status.is_read    = (act_ff == ACTION_READ);
   assign status.has_result = has_result;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_out_session    = osess_ff;
   assign rsp_out_byte       = obyte_ff;
   assign rsp_message_last   = mlast_ff;
   assign rsp_done_slot      = dslot_ff;
   assign rsp_message_length = mlen_ff;
   assign rsp_overflowed     = oovf_ff;

endmodule
